// File: design/vcob_pkg.sv
`timescale 1ns / 1ps
package vcob_pkg;

    localparam int NUM_CHANNELS_DEF      = 8;
    localparam int FLITS_PER_CHANNEL_DEF = 16;
    localparam int CONTROL_DEPTH_DEF     = 16;
    localparam int NONSPEC_MAX           = 2047;

    localparam logic [2:0] MODE_QDATA = 3'd0;
    localparam logic [2:0] MODE_QCTRL = 3'd1;
    localparam logic [2:0] MODE_SEND  = 3'd2;
    localparam logic [2:0] MODE_TAKE  = 3'd3;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_FLIT = 2'd1;
    localparam logic [1:0] ERR_SLOT = 2'd2;
    localparam logic [1:0] ERR_CTRL = 2'd3;

    localparam logic [1:0] CFG_PKT_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_SPEC_LIMIT = 2'd1;
    localparam logic [1:0] CFG_SPEC_MASK  = 2'd2;
    localparam logic [1:0] CFG_CTL_LIMIT  = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  chan;
        logic [31:0] flit_data;
        logic        is_head;
        logic        is_tail;
        logic [31:0] now_time;
    } vcob_in_t;

    typedef struct packed {
        logic        sent_valid;
        logic [31:0] sent_data;
        logic [2:0]  sent_chan;
        logic        sent_head;
        logic        sent_tail;
        logic        sent_control;
        logic [7:0]  full_flags;
        logic        control_full;
        logic [4:0]  control_count;
        logic [4:0]  chan_count;
        logic [1:0]  error_code;
    } vcob_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FLIT_RD,
        S_FLIT_POP,
        S_AGE_RD,
        S_AGE_LD,
        S_CTL_RD,
        S_CTL_POP,
        S_FIN
    } vcob_state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic sel_last;
        logic scan_start;
        logic scan_step;
        logic flit_read;
        logic flit_pop;
        logic age_read;
        logic age_load;
        logic ctl_read;
        logic ctl_pop;
        logic out_load;
    } vcob_cmd_t;

    typedef struct packed {
        logic mode_send;
        logic ctl_nonempty;
        logic cont_last;
        logic scan_done;
        logic scan_found;
        logic age_reload;
        logic out_free;
    } vcob_stat_t;

endpackage

// File: design/vcob_ctrl.sv
`timescale 1ns / 1ps
module vcob_ctrl
    import vcob_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  vcob_stat_t stat,
    output vcob_cmd_t  cmd
);

    vcob_state_t state_reg;
    vcob_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (!stat.mode_send)
                begin
                    state_next = S_FIN;
                end
                else if (stat.ctl_nonempty)
                begin
                    state_next = S_CTL_RD;
                end
                else if (stat.cont_last)
                begin
                    cmd.sel_last = 1'b1;
                    state_next   = S_FLIT_RD;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = stat.scan_found ? S_FLIT_RD : S_FIN;
                end
            end
            S_FLIT_RD:
            begin
                cmd.flit_read = 1'b1;
                state_next    = S_FLIT_POP;
            end
            S_FLIT_POP:
            begin
                cmd.flit_pop = 1'b1;
                state_next   = stat.age_reload ? S_AGE_RD : S_FIN;
            end
            S_AGE_RD:
            begin
                cmd.age_read = 1'b1;
                state_next   = S_AGE_LD;
            end
            S_AGE_LD:
            begin
                cmd.age_load = 1'b1;
                state_next   = S_FIN;
            end
            S_CTL_RD:
            begin
                cmd.ctl_read = 1'b1;
                state_next   = S_CTL_POP;
            end
            S_CTL_POP:
            begin
                cmd.ctl_pop = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/vcob_datapath.sv
`timescale 1ns / 1ps
module vcob_datapath
    import vcob_pkg::*;
#(
    parameter int NUM_CHANNELS      = NUM_CHANNELS_DEF,
    parameter int FLITS_PER_CHANNEL = FLITS_PER_CHANNEL_DEF,
    parameter int CONTROL_DEPTH     = CONTROL_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  vcob_in_t   in_data,
    input  logic       out_ready,
    output logic       out_valid,
    output vcob_out_t  out_data,
    input  logic       cfg_valid,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  vcob_cmd_t  cmd,
    output vcob_stat_t stat
);

    localparam int N    = NUM_CHANNELS;
    localparam int F    = FLITS_PER_CHANNEL;
    localparam int C    = CONTROL_DEPTH;
    localparam int NW   = (N > 1) ? $clog2(N) : 1;
    localparam int PW   = $clog2(F);
    localparam int CNTW = $clog2(F + 1);
    localparam int AW   = $clog2(N * F);
    localparam int CPW  = (C > 1) ? $clog2(C) : 1;
    localparam int CCW  = $clog2(C + 1);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(F - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [CNTW-1:0] n);
        logic [PW:0] s;
        s = (PW + 1)'(p) + (PW + 1)'(n);
        ptr_add = (s >= (PW + 1)'(F)) ? PW'(s - (PW + 1)'(F)) : PW'(s);
    endfunction

    function automatic logic [AW-1:0] mem_addr(input logic [NW-1:0] c, input logic [PW-1:0] p);
        mem_addr = AW'(AW'(c) * AW'(F) + AW'(p));
    endfunction

    // configuration
    logic [7:0] pkt_limit_reg;
    logic [7:0] spec_limit_reg;
    logic [7:0] spec_mask_reg;
    logic [4:0] ctl_limit_reg;

    // channel state
    logic [PW-1:0]   ch_rd_reg   [N];
    logic [CNTW-1:0] ch_cnt_reg  [N];
    logic [PW-1:0]   ag_rd_reg   [N];
    logic [CNTW-1:0] ag_cnt_reg  [N];
    logic [31:0]     head_age_reg[N];
    logic [N-1:0]    lwt_reg;
    logic [7:0]      slots_reg   [N];
    logic [10:0]     nonspec_reg;
    logic [NW-1:0]   last_served_reg;
    logic [CPW-1:0]  ctl_rd_reg;
    logic [CCW-1:0]  ctl_cnt_reg;

    // item and scan
    vcob_in_t        item_reg;
    logic [NW-1:0]   scan_i_reg;
    logic            found_reg;
    logic [31:0]     best_reg;
    logic [NW-1:0]   sel_reg;

    // result
    logic            res_sv_reg;
    logic [31:0]     res_sd_reg;
    logic [2:0]      res_sc_reg;
    logic            res_sh_reg;
    logic            res_st_reg;
    logic            res_sctl_reg;
    logic [1:0]      err_reg;
    logic            out_valid_reg;
    vcob_out_t       out_data_reg;

    // memories
    logic [33:0]     flit_mem[N * F];
    logic [31:0]     age_mem [N * F];
    logic [33:0]     ctl_mem [C];
    logic [33:0]     flit_rd_reg;
    logic [31:0]     age_rd_reg;
    logic [33:0]     ctl_rd_data_reg;

    logic [NW-1:0]   ch_i;
    logic            chan_ok;
    logic            q_ovf;
    logic            q_data_wr;
    logic            q_ctl_wr;
    logic            take_over;
    logic            take_ok;
    logic            spec_i;
    logic [7:0]      full_flags;
    logic [NW:0]     idx_sum;
    logic [NW-1:0]   idx;
    logic [31:0]     idx_age;
    logic            idx_busy;
    logic            idx_hit;
    logic            idx_better;
    logic            pop_tail;
    logic            sel_spec;

    assign ch_i      = item_reg.chan[NW-1:0];
    assign chan_ok   = {1'b0, item_reg.chan} < 4'(N);
    assign spec_i    = spec_mask_reg[ch_i];
    assign q_ovf     = (ch_cnt_reg[ch_i] >= CNTW'(F))
                       || (item_reg.is_head && ag_cnt_reg[ch_i] >= CNTW'(F));
    assign q_data_wr = cmd.exec && item_reg.mode == MODE_QDATA && chan_ok && !q_ovf;
    assign q_ctl_wr  = cmd.exec && item_reg.mode == MODE_QCTRL && ctl_cnt_reg < CCW'(C);
    assign take_over = slots_reg[ch_i] >= (spec_i ? spec_limit_reg : pkt_limit_reg);
    assign take_ok   = cmd.exec && item_reg.mode == MODE_TAKE && chan_ok && !take_over;

    generate
        for (genvar g = 0; g < 8; g++)
        begin : g_flags
            if (g < N)
            begin : g_on
                assign full_flags[g] = spec_mask_reg[g]
                    ? (slots_reg[g] >= spec_limit_reg || nonspec_reg != '0)
                    : (slots_reg[g] >= pkt_limit_reg);
            end
            else
            begin : g_off
                assign full_flags[g] = 1'b0;
            end
        end
    endgenerate

    assign idx_sum    = (NW + 1)'(last_served_reg) + (NW + 1)'(scan_i_reg);
    assign idx        = (idx_sum >= (NW + 1)'(N)) ? NW'(idx_sum - (NW + 1)'(N)) : NW'(idx_sum);
    assign idx_busy   = ch_cnt_reg[idx] != '0;
    assign idx_hit    = idx_busy && !lwt_reg[idx];
    assign idx_age    = (ag_cnt_reg[idx] != '0) ? head_age_reg[idx] : 32'hFFFF_FFFF;
    assign idx_better = idx_busy && (!found_reg || idx_age < best_reg);
    assign pop_tail   = flit_rd_reg[33];
    assign sel_spec   = spec_mask_reg[sel_reg];

    assign stat.mode_send    = item_reg.mode == MODE_SEND;
    assign stat.ctl_nonempty = ctl_cnt_reg != '0;
    assign stat.cont_last    = !lwt_reg[last_served_reg] && ch_cnt_reg[last_served_reg] != '0;
    assign stat.scan_done    = idx_hit || scan_i_reg == NW'(N - 1);
    assign stat.scan_found   = found_reg || idx_busy;
    assign stat.age_reload   = pop_tail && ag_cnt_reg[sel_reg] > CNTW'(1);
    assign stat.out_free     = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (q_data_wr)
        begin
            flit_mem[mem_addr(ch_i, ptr_add(ch_rd_reg[ch_i], ch_cnt_reg[ch_i]))] <=
                {item_reg.is_tail, item_reg.is_head, item_reg.flit_data};
        end
        if (cmd.flit_read)
        begin
            flit_rd_reg <= flit_mem[mem_addr(sel_reg, ch_rd_reg[sel_reg])];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_data_wr && item_reg.is_head)
        begin
            age_mem[mem_addr(ch_i, ptr_add(ag_rd_reg[ch_i], ag_cnt_reg[ch_i]))] <=
                item_reg.now_time;
        end
        if (cmd.age_read)
        begin
            age_rd_reg <= age_mem[mem_addr(sel_reg, ag_rd_reg[sel_reg])];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_ctl_wr)
        begin
            ctl_mem[(CPW + 1)'(ctl_rd_reg) + (CPW + 1)'(ctl_cnt_reg) >= (CPW + 1)'(C)
                    ? CPW'((CPW + 1)'(ctl_rd_reg) + (CPW + 1)'(ctl_cnt_reg) - (CPW + 1)'(C))
                    : CPW'((CPW + 1)'(ctl_rd_reg) + (CPW + 1)'(ctl_cnt_reg))] <=
                {item_reg.is_tail, item_reg.is_head, item_reg.flit_data};
        end
        if (cmd.ctl_read)
        begin
            ctl_rd_data_reg <= ctl_mem[ctl_rd_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_limit_reg   <= 8'd4;
            spec_limit_reg  <= 8'd4;
            spec_mask_reg   <= 8'd0;
            ctl_limit_reg   <= 5'd16;
            lwt_reg         <= '1;
            nonspec_reg     <= '0;
            last_served_reg <= '0;
            ctl_rd_reg      <= '0;
            ctl_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            for (int c = 0; c < N; c++)
            begin
                ch_rd_reg[c]  <= '0;
                ch_cnt_reg[c] <= '0;
                ag_rd_reg[c]  <= '0;
                ag_cnt_reg[c] <= '0;
                slots_reg[c]  <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_PKT_LIMIT:  pkt_limit_reg  <= cfg_data;
                    CFG_SPEC_LIMIT: spec_limit_reg <= cfg_data;
                    CFG_SPEC_MASK:  spec_mask_reg  <= cfg_data;
                    CFG_CTL_LIMIT:  ctl_limit_reg  <= cfg_data[4:0];
                    default:        ctl_limit_reg  <= ctl_limit_reg;
                endcase
            end
            if (q_data_wr)
            begin
                ch_cnt_reg[ch_i] <= ch_cnt_reg[ch_i] + 1'b1;
                if (item_reg.is_head)
                begin
                    ag_cnt_reg[ch_i] <= ag_cnt_reg[ch_i] + 1'b1;
                end
            end
            if (q_ctl_wr)
            begin
                ctl_cnt_reg <= ctl_cnt_reg + 1'b1;
            end
            if (take_ok)
            begin
                slots_reg[ch_i] <= slots_reg[ch_i] + 1'b1;
                if (!spec_i && nonspec_reg < 11'(NONSPEC_MAX))
                begin
                    nonspec_reg <= nonspec_reg + 1'b1;
                end
            end
            if (cmd.flit_pop)
            begin
                ch_rd_reg[sel_reg]  <= ptr_inc(ch_rd_reg[sel_reg]);
                ch_cnt_reg[sel_reg] <= ch_cnt_reg[sel_reg] - 1'b1;
                lwt_reg[sel_reg]    <= pop_tail;
                last_served_reg     <= pop_tail
                    ? ((sel_reg == NW'(N - 1)) ? '0 : sel_reg + 1'b1)
                    : sel_reg;
                if (pop_tail)
                begin
                    if (slots_reg[sel_reg] != '0)
                    begin
                        slots_reg[sel_reg] <= slots_reg[sel_reg] - 1'b1;
                    end
                    if (!sel_spec && nonspec_reg != '0)
                    begin
                        nonspec_reg <= nonspec_reg - 1'b1;
                    end
                    if (ag_cnt_reg[sel_reg] != '0)
                    begin
                        ag_rd_reg[sel_reg]  <= ptr_inc(ag_rd_reg[sel_reg]);
                        ag_cnt_reg[sel_reg] <= ag_cnt_reg[sel_reg] - 1'b1;
                    end
                end
            end
            if (cmd.ctl_pop)
            begin
                ctl_rd_reg  <= (ctl_rd_reg == CPW'(C - 1)) ? '0 : ctl_rd_reg + 1'b1;
                ctl_cnt_reg <= ctl_cnt_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg     <= in_data;
            res_sv_reg   <= 1'b0;
            res_sd_reg   <= '0;
            res_sc_reg   <= '0;
            res_sh_reg   <= 1'b0;
            res_st_reg   <= 1'b0;
            res_sctl_reg <= 1'b0;
            err_reg      <= ERR_NONE;
        end
        if (cmd.exec)
        begin
            if (item_reg.mode == MODE_QDATA && chan_ok && q_ovf)
            begin
                err_reg <= ERR_FLIT;
            end
            if (item_reg.mode == MODE_QCTRL && !q_ctl_wr)
            begin
                err_reg <= ERR_CTRL;
            end
            if (item_reg.mode == MODE_TAKE && chan_ok && take_over)
            begin
                err_reg <= ERR_SLOT;
            end
        end
        if (q_data_wr && item_reg.is_head && ag_cnt_reg[ch_i] == '0)
        begin
            head_age_reg[ch_i] <= item_reg.now_time;
        end
        if (cmd.age_load)
        begin
            head_age_reg[sel_reg] <= age_rd_reg;
        end
        if (cmd.sel_last)
        begin
            sel_reg <= last_served_reg;
        end
        if (cmd.scan_start)
        begin
            scan_i_reg <= '0;
            found_reg  <= 1'b0;
        end
        if (cmd.scan_step)
        begin
            scan_i_reg <= scan_i_reg + 1'b1;
            if (idx_hit || idx_better)
            begin
                sel_reg   <= idx;
                found_reg <= 1'b1;
                best_reg  <= idx_age;
            end
        end
        if (cmd.flit_pop)
        begin
            res_sv_reg <= 1'b1;
            res_sd_reg <= flit_rd_reg[31:0];
            res_sc_reg <= 3'(sel_reg);
            res_sh_reg <= flit_rd_reg[32];
            res_st_reg <= flit_rd_reg[33];
        end
        if (cmd.ctl_pop)
        begin
            res_sv_reg   <= 1'b1;
            res_sctl_reg <= 1'b1;
            res_sd_reg   <= ctl_rd_data_reg[31:0];
            res_sh_reg   <= ctl_rd_data_reg[32];
            res_st_reg   <= ctl_rd_data_reg[33];
        end
        if (cmd.out_load)
        begin
            out_data_reg.sent_valid    <= res_sv_reg;
            out_data_reg.sent_data     <= res_sd_reg;
            out_data_reg.sent_chan     <= res_sc_reg;
            out_data_reg.sent_head     <= res_sh_reg;
            out_data_reg.sent_tail     <= res_st_reg;
            out_data_reg.sent_control  <= res_sctl_reg;
            out_data_reg.full_flags    <= full_flags;
            out_data_reg.control_full  <= 5'(ctl_cnt_reg) >= ctl_limit_reg;
            out_data_reg.control_count <= 5'(ctl_cnt_reg);
            out_data_reg.chan_count    <= chan_ok ? 5'(ch_cnt_reg[ch_i]) : 5'd0;
            out_data_reg.error_code    <= err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: design/vc_output_buffer_age_arbiter.sv
`timescale 1ns / 1ps
// Virtual-channel output buffer with a strict-priority control queue and an
// oldest-first send arbiter. One item is handled at a time. A send takes a
// control flit when one is queued, else continues the last packet, and
// otherwise the arbiter scans the channels one per cycle from the last-served
// pointer; a send includes the flit memory read and, after a tail that leaves
// further head ages, the head-age reload. The next item is taken while a result
// still waits in the output register.
module vc_output_buffer_age_arbiter
    import vcob_pkg::*;
#(
    parameter int NUM_CHANNELS      = NUM_CHANNELS_DEF,
    parameter int FLITS_PER_CHANNEL = FLITS_PER_CHANNEL_DEF,
    parameter int CONTROL_DEPTH     = CONTROL_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  vcob_in_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output vcob_out_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    vcob_cmd_t  cmd;
    vcob_stat_t stat;

    assign cfg_ready = 1'b1;

    vcob_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vcob_datapath #(
        .NUM_CHANNELS      (NUM_CHANNELS),
        .FLITS_PER_CHANNEL (FLITS_PER_CHANNEL),
        .CONTROL_DEPTH     (CONTROL_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

    a_ctl_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.control_count <= 5'(CONTROL_DEPTH))
        else $error("control count beyond depth");

    a_ctl_sent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.sent_control |->
            out_data.sent_valid && out_data.sent_chan == 3'd0)
        else $error("control flit result malformed");

    a_err_no_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_code != ERR_NONE |-> !out_data.sent_valid)
        else $error("error reported with a sent flit");

endmodule

// File: test/vc_output_buffer_age_arbiter_test.sv
`timescale 1ns / 1ps
module vc_output_buffer_age_arbiter_test;
    import vcob_pkg::*;

    localparam int NCH = 8;
    localparam int FPC = 16;
    localparam int CDEPTH = 16;
    localparam int STALL_LIMIT = 20000;
    localparam logic [2:0] MODE_QUERY = 3'd4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    vcob_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    vcob_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    vc_output_buffer_age_arbiter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    logic [33:0] flits [NCH][FPC];
    logic [31:0] ages [NCH][FPC];
    int ch_rd [NCH];
    int ch_cnt [NCH];
    int ag_rd [NCH];
    int ag_cnt [NCH];
    logic [33:0] ctl_q [CDEPTH];
    int ctl_rd, ctl_cnt;
    bit tail_seen [NCH];
    int last_served;
    int slots [NCH];
    int nonspec;
    logic [7:0] pkt_limit, spec_limit, spec_mask;
    logic [4:0] ctl_limit;

    vcob_out_t expected_q[$];
    int mismatches = 0;
    int n_items = 0;
    int n_results = 0;
    int n_sends = 0;
    int idle_cycles = 0;
    int rx_wait = 0;
    bit hold_off = 1'b0;
    bit long_stall = 1'b0;

    function automatic bit chan_full(int c);
        if (spec_mask[c])
            return slots[c] >= spec_limit || nonspec > 0;
        return slots[c] >= pkt_limit;
    endfunction

    function automatic logic [31:0] head_age(int c);
        if (ag_cnt[c] == 0)
            return 32'hFFFF_FFFF;
        return ages[c][ag_rd[c]];
    endfunction

    function automatic vcob_out_t buffer_step(vcob_in_t it);
        vcob_out_t r;
        int c, sel, ls, idx, w, lim;
        bit found;
        logic [31:0] best;
        logic [33:0] e;
        r = '0;
        c = it.chan;
        if (it.mode == MODE_QDATA) begin
            if (ch_cnt[c] >= FPC || (it.is_head && ag_cnt[c] >= FPC))
                r.error_code = ERR_FLIT;
            else
            begin
                w = (ch_rd[c] + ch_cnt[c]) % FPC;
                flits[c][w] = {it.is_tail, it.is_head, it.flit_data};
                ch_cnt[c]++;
                if (it.is_head)
                begin
                    w = (ag_rd[c] + ag_cnt[c]) % FPC;
                    ages[c][w] = it.now_time;
                    ag_cnt[c]++;
                end
            end
        end
        else if (it.mode == MODE_QCTRL) begin
            if (ctl_cnt >= CDEPTH)
                r.error_code = ERR_CTRL;
            else
            begin
                ctl_q[(ctl_rd + ctl_cnt) % CDEPTH] = {it.is_tail, it.is_head, it.flit_data};
                ctl_cnt++;
            end
        end
        else if (it.mode == MODE_SEND) begin
            if (ctl_cnt > 0)
            begin
                e = ctl_q[ctl_rd];
                ctl_rd = (ctl_rd + 1) % CDEPTH;
                ctl_cnt--;
                r.sent_valid = 1'b1;
                r.sent_control = 1'b1;
                {r.sent_tail, r.sent_head, r.sent_data} = e;
            end
            else
            begin
                ls = last_served;
                found = 1'b0;
                sel = 0;
                best = '0;
                if (!tail_seen[ls] && ch_cnt[ls] > 0)
                begin
                    sel = ls;
                    found = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < NCH; i++)
                    begin
                        idx = (i + ls) % NCH;
                        if (ch_cnt[idx] != 0)
                        begin
                            if (!tail_seen[idx])
                            begin
                                sel = idx;
                                found = 1'b1;
                                break;
                            end
                            if (!found || head_age(idx) < best)
                            begin
                                best = head_age(idx);
                                sel = idx;
                                found = 1'b1;
                            end
                        end
                    end
                end
                if (found)
                begin
                    e = flits[sel][ch_rd[sel]];
                    ch_rd[sel] = (ch_rd[sel] + 1) % FPC;
                    ch_cnt[sel]--;
                    r.sent_valid = 1'b1;
                    r.sent_chan = 3'(sel);
                    {r.sent_tail, r.sent_head, r.sent_data} = e;
                    last_served = sel;
                    tail_seen[sel] = e[33];
                    if (e[33])
                    begin
                        if (slots[sel] > 0)
                            slots[sel]--;
                        if (!spec_mask[sel] && nonspec > 0)
                            nonspec--;
                        if (ag_cnt[sel] > 0)
                        begin
                            ag_rd[sel] = (ag_rd[sel] + 1) % FPC;
                            ag_cnt[sel]--;
                        end
                        last_served = (sel + 1) % NCH;
                    end
                end
            end
        end
        else if (it.mode == MODE_TAKE) begin
            lim = spec_mask[c] ? spec_limit : pkt_limit;
            if (slots[c] >= lim)
                r.error_code = ERR_SLOT;
            else
            begin
                slots[c]++;
                if (!spec_mask[c] && nonspec < NONSPEC_MAX)
                    nonspec++;
            end
        end
        for (int k = 0; k < NCH; k++)
            r.full_flags[k] = chan_full(k);
        r.control_full = ctl_cnt >= ctl_limit;
        r.control_count = 5'(ctl_cnt);
        r.chan_count = 5'(ch_cnt[c]);
        return r;
    endfunction

    task automatic clear_model();
        for (int c = 0; c < NCH; c++)
        begin
            ch_rd[c] = 0; ch_cnt[c] = 0; ag_rd[c] = 0; ag_cnt[c] = 0;
            tail_seen[c] = 1'b1; slots[c] = 0;
        end
        ctl_rd = 0; ctl_cnt = 0; last_served = 0; nonspec = 0;
        pkt_limit = 8'd4; spec_limit = 8'd4; spec_mask = 8'd0; ctl_limit = 5'd16;
    endtask

    task automatic send_item(input vcob_in_t it);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(buffer_step(it));
        n_items++;
        if (it.mode == MODE_SEND)
            n_sends++;
    endtask

    function automatic vcob_in_t make_item(logic [2:0] m, int c, bit h, bit t);
        vcob_in_t it;
        it.mode = m;
        it.chan = 3'(c);
        it.flit_data = $urandom;
        it.is_head = h;
        it.is_tail = t;
        it.now_time = $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom;
        return it;
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PKT_LIMIT: pkt_limit = val;
            CFG_SPEC_LIMIT: spec_limit = val;
            CFG_SPEC_MASK: spec_mask = val;
            default: ctl_limit = val[4:0];
        endcase
    endtask

    task automatic send_packet(int c, int len);
        for (int k = 0; k < len; k++)
            send_item(make_item(MODE_QDATA, c, k == 0, k == len - 1));
    endtask

    task automatic test_directed();
        vcob_in_t it;
        it = '0;
        it.mode = MODE_SEND;
        send_item(it);
        it = '1;
        it.mode = MODE_QDATA;
        it.chan = 3'd7;
        send_item(it);
        it.now_time = '0;
        it.chan = 3'd0;
        it.flit_data = '0;
        it.is_tail = 1'b0;
        send_item(it);
        send_item(make_item(MODE_QDATA, 2, 1'b0, 1'b1));
        send_item(make_item(MODE_QCTRL, 0, 1'b1, 1'b1));
        for (int k = 0; k < 5; k++)
            send_item(make_item(MODE_SEND, 0, 1'b0, 1'b0));
        for (int k = 0; k < 5; k++)
            send_item(make_item(MODE_TAKE, 1, 1'b0, 1'b0));
        send_item(make_item(3'd5, 7, 1'b1, 1'b0));
        send_item(make_item(3'd7, 4, 1'b0, 1'b1));
        send_item(make_item(MODE_QUERY, 1, 1'b0, 1'b0));
    endtask

    task automatic test_overflow();
        for (int k = 0; k < FPC + 1; k++)
            send_item(make_item(MODE_QDATA, 5, 1'b1, 1'b1));
        for (int k = 0; k < CDEPTH + 1; k++)
            send_item(make_item(MODE_QCTRL, 0, k[0], 1'b0));
        for (int k = 0; k < FPC + CDEPTH + 6; k++)
            send_item(make_item(MODE_SEND, 0, 1'b0, 1'b0));
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int k = 0; k < 20; k++)
            send_item(make_item(MODE_QUERY, k % NCH, 1'b0, 1'b0));
        hold_off = 1'b0;
        drain();
    endtask

    task automatic test_random(int count);
        int c, len, r;
        while (count > 0)
        begin
            r = $urandom_range(0, 9);
            c = $urandom_range(0, NCH - 1);
            if (r < 4)
            begin
                len = $urandom_range(1, 4);
                send_item(make_item(MODE_TAKE, c, 1'b0, 1'b0));
                send_packet(c, len);
                count -= len + 1;
            end
            else if (r < 8)
            begin
                send_item(make_item(MODE_SEND, c, 1'b0, 1'b0));
                count--;
            end
            else
            begin
                send_item(make_item(3'($urandom_range(0, 7)), c, 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1))));
                count--;
            end
        end
        while (ch_cnt.sum() + ctl_cnt > 0)
            send_item(make_item(MODE_SEND, 0, 1'b0, 1'b0));
    endtask

    task automatic test_configs();
        write_reg(CFG_PKT_LIMIT, 8'd1);
        write_reg(CFG_SPEC_LIMIT, 8'd255);
        write_reg(CFG_SPEC_MASK, 8'hAA);
        write_reg(CFG_CTL_LIMIT, 8'd1);
        test_random(200);
        write_reg(CFG_PKT_LIMIT, 8'd255);
        write_reg(CFG_SPEC_LIMIT, 8'd1);
        write_reg(CFG_SPEC_MASK, 8'hFF);
        write_reg(CFG_CTL_LIMIT, 8'd16);
        test_random(200);
        write_reg(CFG_PKT_LIMIT, 8'd3);
        write_reg(CFG_SPEC_LIMIT, 8'd2);
        write_reg(CFG_SPEC_MASK, 8'h0F);
        write_reg(CFG_CTL_LIMIT, 8'd5);
        test_random(200);
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            n_results++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item %p", out_data);
            end
            else if (out_data !== expected_q[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch expected %p actual %p", expected_q[0], out_data);
                void'(expected_q.pop_front());
            end
            else
                void'(expected_q.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (hold_off && !long_stall)
        begin
            long_stall <= 1'b1;
            out_ready <= 1'b0;
            repeat (300) @(posedge clk);
            long_stall <= 1'b0;
            out_ready <= 1'b1;
            rx_wait = 0;
            @(posedge clk);
            while (hold_off)
                @(posedge clk);
        end
        else if (!long_stall)
        begin
            if (out_valid && out_ready)
            begin
                rx_wait = $urandom_range(0, 10);
                out_ready <= rx_wait == 0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= rx_wait == 0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        clear_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_random(150);
        test_configs();
        drain();
        $display("covered %0d items, %0d sends, %0d results, four register settings",
                 n_items, n_sends, n_results);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
